/* hdl/bffs_pkg.sv */
// bffs_pkg: shared constants for the bitmap first-fit search
// no dependencies
`default_nettype none
package bffs_pkg;
	localparam int MapWordsDef = 16;
	localparam int WordBitsDef = 64;
	localparam int DataW = 64;
	localparam int ReqW = 11;
	localparam int IdxW = 4;
	localparam int PosW = 10;
	localparam int CfgW = 5;
	localparam logic [CfgW-1:0] WordsReset = 5'd16;
	localparam logic CmdWrite = 1'b0;
	localparam logic CmdFind = 1'b1;
endpackage
`default_nettype wire

/* hdl/bffs_if.sv */
// bffs_in_if, bffs_out_if: valid/ready channels of the search block
// depends on bffs_pkg
`default_nettype none
interface bffs_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [bffs_pkg::IdxW-1:0] word_index;
	logic [bffs_pkg::DataW-1:0] word_data;
	logic [bffs_pkg::ReqW-1:0] request_length;
	modport source (output valid, cmd, word_index, word_data, request_length, input ready);
	modport sink (input valid, cmd, word_index, word_data, request_length, output ready);
endinterface

interface bffs_out_if;
	logic valid;
	logic ready;
	logic found;
	logic [bffs_pkg::PosW-1:0] start_position;
	modport source (output valid, found, start_position, input ready);
	modport sink (input valid, found, start_position, output ready);
endinterface
`default_nettype wire

/* hdl/bffs_cell.sv */
// bffs_cell: one map word that rotates through the row of cells
// depends on bffs_pkg
`default_nettype none
module bffs_cell #(
	parameter int WORD_BITS = bffs_pkg::WordBitsDef
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 shift,
	input  wire logic                 wr_en,
	input  wire logic [WORD_BITS-1:0] wr_data,
	input  wire logic [WORD_BITS-1:0] prev_word,
	output logic      [WORD_BITS-1:0] word
);
	logic [WORD_BITS-1:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (wr_en) begin
			word_q <= wr_data;
		end else if (shift) begin
			word_q <= prev_word;
		end
	end

	assign word = word_q;
endmodule
`default_nettype wire

/* hdl/bitmap_first_fit_search.sv */
// bitmap_first_fit_search: first-fit free run search over a rotating row of map words
// a write loads one map word; a find checks one position a cycle
// while the row of cells rotates once around; the scan sets the rate
// reset clears every map word to free and words_in_use to 16
// depends on bffs_pkg, bffs_in_if, bffs_out_if, bffs_cell
`default_nettype none
module bitmap_first_fit_search #(
	parameter int MAP_WORDS = bffs_pkg::MapWordsDef,
	parameter int WORD_BITS = bffs_pkg::WordBitsDef
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [bffs_pkg::CfgW-1:0]  cfg_wdata,
	bffs_in_if.sink                         in_ch,
	bffs_out_if.source                      out_ch
);
	localparam int BitW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int WordW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int TotW = $clog2(MAP_WORDS * WORD_BITS + 1) + 1;
	localparam int CntW = (TotW > bffs_pkg::ReqW) ? TotW : bffs_pkg::ReqW;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StScan = 2'd1;
	localparam logic [1:0] StDone = 2'd2;

	logic [1:0] state_q;
	logic [bffs_pkg::CfgW-1:0] words_q;
	logic [WORD_BITS-1:0] words [MAP_WORDS];
	logic [BitW-1:0] bit_q;
	logic [WordW:0] wcnt_q;
	logic [WordW:0] wlim_q;
	logic [CntW-1:0] pos_q, run_q, req_q, end_q;
	logic found_q;
	logic [bffs_pkg::PosW-1:0] start_q;
	logic out_valid_q;
	logic shift;
	logic wr_hit;
	logic cur_used;
	logic [CntW-1:0] run_nx;
	logic [CntW-1:0] words_sat;

	assign in_ch.ready = (state_q == StIdle) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.found = found_q;
	assign out_ch.start_position = start_q;

	assign shift = (state_q == StScan) && (bit_q == BitW'(WORD_BITS - 1));
	assign wr_hit = in_ch.valid && in_ch.ready && (in_ch.cmd == bffs_pkg::CmdWrite)
		&& (32'(in_ch.word_index) < MAP_WORDS);
	assign words_sat = (32'(words_q) > MAP_WORDS) ? CntW'(MAP_WORDS) : CntW'(words_q);

	for (genvar g = 0; g < MAP_WORDS; g++) begin : g_cell
		bffs_cell #(.WORD_BITS(WORD_BITS)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.shift(shift),
			.wr_en(wr_hit && (32'(in_ch.word_index) == g)),
			.wr_data(in_ch.word_data[WORD_BITS-1:0]),
			.prev_word(words[(g + 1) % MAP_WORDS]),
			.word(words[g])
		);
	end

	assign cur_used = (wcnt_q >= wlim_q) ? 1'b1 : words[0][WORD_BITS - 1 - 32'(bit_q)];
	assign run_nx = cur_used ? '0 : run_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= bffs_pkg::WordsReset;
		end else if (cfg_we) begin
			words_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			out_valid_q <= 1'b0;
			bit_q <= '0;
			wcnt_q <= '0;
			wlim_q <= '0;
			pos_q <= '0;
			run_q <= '0;
			req_q <= '0;
			end_q <= '0;
			found_q <= 1'b0;
			start_q <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				StIdle: begin
					if (in_ch.valid && in_ch.ready && in_ch.cmd == bffs_pkg::CmdFind) begin
						state_q <= StScan;
						bit_q <= '0;
						wcnt_q <= '0;
						pos_q <= '0;
						run_q <= '0;
						wlim_q <= (WordW + 1)'(words_sat);
						end_q <= CntW'(words_sat * CntW'(WORD_BITS));
						req_q <= CntW'(in_ch.request_length);
						found_q <= 1'b0;
						start_q <= '0;
					end
				end
				StScan: begin
					if (!found_q) begin
						if (end_q != '0 && req_q == '0) begin
							found_q <= 1'b1;
							start_q <= '0;
						end else if (req_q <= end_q && !cur_used && run_nx >= req_q) begin
							found_q <= 1'b1;
							start_q <= bffs_pkg::PosW'(pos_q + 1'b1 - req_q);
						end
					end
					run_q <= run_nx;
					pos_q <= pos_q + 1'b1;
					bit_q <= (bit_q == BitW'(WORD_BITS - 1)) ? '0 : bit_q + 1'b1;
					if (bit_q == BitW'(WORD_BITS - 1)) begin
						wcnt_q <= wcnt_q + 1'b1;
						if (32'(wcnt_q) == MAP_WORDS - 1) begin
							state_q <= StDone;
						end
					end
				end
				StDone: begin
					out_valid_q <= 1'b1;
					state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != StIdle) |-> !in_ch.ready) else $error("accept while busy");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StDone) |=> out_valid_q) else $error("result missing");
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (start_q == '0)) else $error("bad start");
`endif
endmodule
`default_nettype wire
